// ===== hdl/bc3tbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bc3tbd_pkg
// Shared types, constants and arithmetic helpers of the BC3 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bc3tbd_pkg;

    // texels in one 4x4 block
    localparam int TEXELS       = 16;
    localparam int TEXEL_W      = $clog2(TEXELS);
    // depth of the queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // reciprocal constants: x/d == (x*m) >> s over the value ranges used here
    // channel expansion folds the *255 into the reciprocal of 31 and 63
    localparam logic [23:0] EXP5_MUL  = 24'd8625630;  // 255 * ceil(2^20/31)
    localparam logic [22:0] EXP6_MUL  = 23'd4244475;  // 255 * ceil(2^20/63)
    localparam logic [15:0] DIV7_MUL  = 16'd9363;     // ceil(2^16/7)
    localparam logic [15:0] DIV5_MUL  = 16'd13108;    // ceil(2^16/5)
    localparam logic [15:0] DIV3_MUL  = 16'd21846;    // ceil(2^16/3)
    localparam logic [7:0]  ALPHA_MAX = 8'd255;
    localparam logic [7:0]  ALPHA_MIN = 8'd0;

    typedef logic [7:0]  t_byte;
    typedef logic [10:0] t_asum;

    typedef struct packed {
        t_byte r;
        t_byte g;
        t_byte b;
    } t_rgb;

    // fully resolved palette of one block plus its per-texel indices
    typedef struct packed {
        t_byte [7:0]  alv;
        t_rgb  [3:0]  col;
        logic  [47:0] aidx;
        logic  [31:0] cidx;
    } t_pal;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // 5-bit channel to 8 bits, truncating v*255/31
    function automatic t_byte expand5(input logic [4:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'(EXP5_MUL);
        return p[27:20];
    endfunction

    // 6-bit channel to 8 bits, truncating v*255/63
    function automatic t_byte expand6(input logic [5:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'(EXP6_MUL);
        return p[27:20];
    endfunction

    // (2*a + b) / 3, truncating
    function automatic t_byte third(input t_byte a, input t_byte b);
        logic [9:0]  s;
        logic [25:0] p;
        s = 10'({a, 1'b0}) + 10'(b);
        p = 26'(s) * 26'(DIV3_MUL);
        return p[23:16];
    endfunction

    // weighted alpha sum divided by 7 or by 5, truncating
    function automatic t_byte alpha_div(input t_asum s, input logic mode7);
        logic [26:0] p;
        p = 27'(s) * 27'(mode7 ? DIV7_MUL : DIV5_MUL);
        return p[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bc3tbd_blk_if.sv =====
// ----------------------------------------------------------------------------
// bc3tbd_blk_if
// Compressed block channel: alpha half and color half of one BC3 block.
// ----------------------------------------------------------------------------
`default_nettype none

interface bc3tbd_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] alpha_half;
    logic [63:0] color_half;

    modport source (output valid, output alpha_half, output color_half, input ready);
    modport sink   (input valid, input alpha_half, input color_half, output ready);
endinterface

`default_nettype wire

// ===== hdl/bc3tbd_txl_if.sv =====
// ----------------------------------------------------------------------------
// bc3tbd_txl_if
// Decoded texel channel: one RGBA8 texel with its position in the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface bc3tbd_txl_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] column;
    logic [1:0] row;
    logic       last_texel;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output column, output row, output last_texel, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input column, input row, input last_texel, output ready);
endinterface

`default_nettype wire

// ===== hdl/bc3tbd_front.sv =====
// ----------------------------------------------------------------------------
// bc3tbd_front
// Accepts compressed blocks and builds the alpha and color palettes in a
// two-stage pipeline, then hands the resolved palette to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bc3tbd_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    bc3tbd_blk_if.sink            i_blk,
    input  wire bc3tbd_pkg::t_q_stat i_q_stat,
    output logic                  o_push,
    output bc3tbd_pkg::t_pal      o_pal
);
    import bc3tbd_pkg::*;

    // stage 1: expanded endpoints and weighted alpha sums
    logic          r_s1_v;
    t_rgb          r_s1_c0, r_s1_c1;
    t_byte         r_s1_a0, r_s1_a1;
    logic          r_s1_mode7;
    t_asum [5:0]   r_s1_asum;
    logic  [47:0]  r_s1_aidx;
    logic  [31:0]  r_s1_cidx;

    // stage 2: resolved palette
    logic          r_s2_v;
    t_pal          r_s2;

    t_byte         n_a0, n_a1;
    logic          n_mode7;
    t_asum [5:0]   n_asum;
    t_pal          n_s2;
    logic          s2_ld, s1_ld;

    // pipeline advance
    assign o_push      = r_s2_v && !i_q_stat.full;
    assign s2_ld       = !r_s2_v || o_push;
    assign s1_ld       = !r_s1_v || s2_ld;
    assign i_blk.ready = s1_ld;
    assign o_pal       = r_s2;

    // alpha endpoints, table mode and weighted sums
    always_comb begin
        n_a0    = i_blk.alpha_half[7:0];
        n_a1    = i_blk.alpha_half[15:8];
        n_mode7 = n_a0 > n_a1;
        for (int k = 1; k <= 6; k++) begin
            if (n_mode7) begin
                n_asum[k-1] = t_asum'(n_a0) * t_asum'(7 - k) + t_asum'(n_a1) * t_asum'(k);
            end else if (k <= 4) begin
                n_asum[k-1] = t_asum'(n_a0) * t_asum'(5 - k) + t_asum'(n_a1) * t_asum'(k);
            end else begin
                n_asum[k-1] = '0;
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ld) begin
            r_s1_v <= i_blk.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ld) begin
            r_s1_c0.r  <= expand5(i_blk.color_half[15:11]);
            r_s1_c0.g  <= expand6(i_blk.color_half[10:5]);
            r_s1_c0.b  <= expand5(i_blk.color_half[4:0]);
            r_s1_c1.r  <= expand5(i_blk.color_half[31:27]);
            r_s1_c1.g  <= expand6(i_blk.color_half[26:21]);
            r_s1_c1.b  <= expand5(i_blk.color_half[20:16]);
            r_s1_a0    <= n_a0;
            r_s1_a1    <= n_a1;
            r_s1_mode7 <= n_mode7;
            r_s1_asum  <= n_asum;
            r_s1_aidx  <= i_blk.alpha_half[63:16];
            r_s1_cidx  <= i_blk.color_half[63:32];
        end
    end

    // alpha levels and the two interpolated colors
    always_comb begin
        n_s2.alv[0] = r_s1_a0;
        n_s2.alv[1] = r_s1_a1;
        for (int k = 1; k <= 6; k++) begin
            n_s2.alv[k+1] = alpha_div(r_s1_asum[k-1], r_s1_mode7);
        end
        // six-level table pins the top two entries
        if (!r_s1_mode7) begin
            n_s2.alv[6] = ALPHA_MIN;
            n_s2.alv[7] = ALPHA_MAX;
        end
        n_s2.col[0]   = r_s1_c0;
        n_s2.col[1]   = r_s1_c1;
        n_s2.col[2].r = third(r_s1_c0.r, r_s1_c1.r);
        n_s2.col[2].g = third(r_s1_c0.g, r_s1_c1.g);
        n_s2.col[2].b = third(r_s1_c0.b, r_s1_c1.b);
        n_s2.col[3].r = third(r_s1_c1.r, r_s1_c0.r);
        n_s2.col[3].g = third(r_s1_c1.g, r_s1_c0.g);
        n_s2.col[3].b = third(r_s1_c1.b, r_s1_c0.b);
        n_s2.aidx     = r_s1_aidx;
        n_s2.cidx     = r_s1_cidx;
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_ld) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ld) begin
            r_s2 <= n_s2;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bc3tbd_queue.sv =====
// ----------------------------------------------------------------------------
// bc3tbd_queue
// Short queue of resolved palettes between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bc3tbd_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bc3tbd_pkg::t_pal i_pal,
    input  wire logic             i_pop,
    output bc3tbd_pkg::t_pal      o_head,
    output bc3tbd_pkg::t_q_stat   o_stat
);
    import bc3tbd_pkg::*;

    t_pal                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr, r_rptr;
    logic [QUEUE_CNT_W-1:0] r_cnt;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head       = r_mem[r_rptr];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_pal;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // no overflow or underflow
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== hdl/bc3tbd_back.sv =====
// ----------------------------------------------------------------------------
// bc3tbd_back
// Walks the sixteen texels of the palette at the queue head, one per cycle
// while the output is taken, into a registered texel output.
// ----------------------------------------------------------------------------
`default_nettype none

module bc3tbd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bc3tbd_pkg::t_pal i_head,
    input  wire bc3tbd_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    bc3tbd_txl_if.source          o_txl
);
    import bc3tbd_pkg::*;

    logic [TEXEL_W-1:0] r_cnt;
    logic               r_o_valid;
    t_byte              r_red, r_green, r_blue, r_alpha;
    logic [1:0]         r_column, r_row;
    logic               r_last;

    logic               adv, load;
    logic [5:0]         a_pos;
    logic [4:0]         c_pos;
    logic [2:0]         ai;
    logic [1:0]         ci;

    // output register advances when empty or taken
    assign adv   = !r_o_valid || o_txl.ready;
    assign load  = adv && !i_q_stat.empty;
    assign o_pop = load && (r_cnt == TEXEL_W'(TEXELS - 1));

    // index fields of the current texel
    assign a_pos = 6'({r_cnt, 1'b0}) + 6'(r_cnt);
    assign c_pos = 5'({r_cnt, 1'b0});
    assign ai    = i_head.aidx[a_pos +: 3];
    assign ci    = i_head.cidx[c_pos +: 2];

    // texel counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_cnt     <= r_cnt + 1'b1;
            r_o_valid <= 1'b1;
        end else if (adv) begin
            r_o_valid <= 1'b0;
        end
    end

    // texel payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_red    <= i_head.col[ci].r;
            r_green  <= i_head.col[ci].g;
            r_blue   <= i_head.col[ci].b;
            r_alpha  <= i_head.alv[ai];
            r_column <= r_cnt[1:0];
            r_row    <= r_cnt[3:2];
            r_last   <= &r_cnt;
        end
    end

    assign o_txl.valid      = r_o_valid;
    assign o_txl.red        = r_red;
    assign o_txl.green      = r_green;
    assign o_txl.blue       = r_blue;
    assign o_txl.alpha      = r_alpha;
    assign o_txl.column     = r_column;
    assign o_txl.row        = r_row;
    assign o_txl.last_texel = r_last;

    // last marker only on the bottom-right texel
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_last) |-> (r_column == 2'd3 && r_row == 2'd3))
        else $error("last texel marker at wrong position");

    // releasing a palette puts its last texel on the output
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_o_valid && r_last))
        else $error("palette released before its last texel");

endmodule

`default_nettype wire

// ===== hdl/bc3_texture_block_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bc3_texture_block_decoder_unit
// BC3 (DXT5) block decoder: one 16-byte block in, sixteen RGBA8 texels out.
// ----------------------------------------------------------------------------
// The unit takes one compressed block per transaction (alpha half and color
// half, little-endian) and returns its sixteen texels in raster order, one
// texel per cycle while the output is taken and a palette is queued, with
// column, row and a last-texel marker on the sixteenth. The sustained block
// rate is set by the one-texel-per-cycle output sequencer. An accepted block
// passes through the first and the second of two front pipeline stages that
// build the alpha table and the four-color palette, then through the queue
// and the output register. The color half always decodes in four-color mode
// regardless of endpoint order; equal alpha endpoints select the six-level
// alpha table. A two-entry palette queue lets new blocks be accepted while
// texels are still drained. No state survives between blocks.
`default_nettype none

module bc3_texture_block_decoder_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bc3tbd_blk_if.sink   i_blk,
    bc3tbd_txl_if.source o_txl
);
    import bc3tbd_pkg::*;

    t_pal    pal_in, pal_head;
    t_q_stat q_stat;
    logic    push, pop;

    // front: accept and build palettes
    bc3tbd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_blk    (i_blk),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_pal    (pal_in)
    );

    // queue between front and back
    bc3tbd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pal    (pal_in),
        .i_pop    (pop),
        .o_head   (pal_head),
        .o_stat   (q_stat)
    );

    // back: texel sequencer
    bc3tbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (pal_head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_txl    (o_txl)
    );

endmodule

`default_nettype wire
